// ----- rtl/rdc_pkg.sv -----
`default_nettype none
package rdc_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] CHAR_NONE   = 7'h00;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_READ,
    BK_SEND,
    BK_ERR
  } bk_state_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic base_err;
  } head_ctl_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < DEC_DIGITS) begin
      return CHAR_ZERO + d_ext;
    end
    return CHAR_LETTER + d_ext;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/rdc_if.sv -----
`default_nettype none
interface rdc_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                       valid;
  logic                       ready;
  logic [VALUE_BITS-1:0]      value_in;
  logic [rdc_pkg::RADIX_W-1:0] radix;

  modport source (output valid, output value_in, output radix, input ready);
  modport sink   (input valid, input value_in, input radix, output ready);
endinterface

interface rdc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rdc_pkg::CHAR_W-1:0] digit_char;
  logic                       last_digit;
  logic                       base_error;

  modport source (output valid, output digit_char, output last_digit, output base_error,
                  input ready);
  modport sink   (input valid, input digit_char, input last_digit, input base_error,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/rdc_front.sv -----
`default_nettype none
module rdc_front #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  rdc_in_if.sink                           req,
  output rdc_pkg::head_ctl_t               head,
  output logic [VALUE_BITS-1:0]            head_value,
  output logic [rdc_pkg::RADIX_W-1:0]      head_radix,
  input  wire logic                        pop
);

  localparam int DEPTH = 2;

  logic [VALUE_BITS-1:0]       q_value [DEPTH];
  logic [rdc_pkg::RADIX_W-1:0] q_radix [DEPTH];
  logic                        q_err   [DEPTH];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        push;
  logic                        do_pop;
  logic                        in_err;

  assign in_err = (req.radix < rdc_pkg::RADIX_MIN) || (req.radix > rdc_pkg::RADIX_MAX);
  assign req.ready = (count != 2'(DEPTH));
  assign push   = req.valid && req.ready;
  assign do_pop = pop && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_value[wr_ptr] <= req.value_in;
      q_radix[wr_ptr] <= req.radix;
      q_err[wr_ptr]   <= in_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, do_pop};
    end
  end

  assign head.valid    = (count != 2'd0);
  assign head.base_err = q_err[rd_ptr];
  assign head_value    = q_value[rd_ptr];
  assign head_radix    = q_radix[rd_ptr];

endmodule
`default_nettype wire

// ----- rtl/rdc_back.sv -----
`default_nettype none
module rdc_back #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire rdc_pkg::head_ctl_t          head,
  input  wire logic [VALUE_BITS-1:0]       head_value,
  input  wire logic [rdc_pkg::RADIX_W-1:0] head_radix,
  output logic                             pop,
  rdc_out_if.source                        rsp
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int RW    = rdc_pkg::RADIX_W;

  rdc_pkg::bk_state_t state, state_next;

  logic [VALUE_BITS-1:0]     quo, quo_next;
  logic [RW-1:0]             rem, rem_next;
  logic [RW-1:0]             radix_r, radix_r_next;
  logic [BIT_W-1:0]          bit_cnt, bit_cnt_next;
  logic [IDX_W-1:0]          wr_ptr, wr_ptr_next;
  logic [IDX_W-1:0]          idx, idx_next;

  logic                      out_valid, out_valid_next;
  logic [rdc_pkg::CHAR_W-1:0] out_char, out_char_next;
  logic                      out_last, out_last_next;
  logic                      out_err, out_err_next;

  logic [RW-1:0]             digit_mem [VALUE_BITS];
  logic [RW-1:0]             rd_data;
  logic                      mem_we;
  logic                      rd_en;

  logic [RW:0]               trial;
  logic                      ge;
  logic [RW-1:0]             rem_step;
  logic [RW:0]               diff;
  logic [VALUE_BITS-1:0]     quo_step;
  logic                      out_free;

  assign trial    = {rem, quo[VALUE_BITS-1]};
  assign ge       = (trial >= {1'b0, radix_r});
  assign diff     = trial - {1'b0, radix_r};
  assign rem_step = ge ? diff[RW-1:0] : trial[RW-1:0];
  assign quo_step = {quo[VALUE_BITS-2:0], ge};
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[wr_ptr] <= rem_step;
    end
    if (rd_en) begin
      rd_data <= digit_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdc_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
    quo      <= quo_next;
    rem      <= rem_next;
    radix_r  <= radix_r_next;
    bit_cnt  <= bit_cnt_next;
    wr_ptr   <= wr_ptr_next;
    idx      <= idx_next;
    out_char <= out_char_next;
    out_last <= out_last_next;
    out_err  <= out_err_next;
  end

  always_comb begin
    state_next     = state;
    quo_next       = quo;
    rem_next       = rem;
    radix_r_next   = radix_r;
    bit_cnt_next   = bit_cnt;
    wr_ptr_next    = wr_ptr;
    idx_next       = idx;
    out_valid_next = out_valid && !rsp.ready;
    out_char_next  = out_char;
    out_last_next  = out_last;
    out_err_next   = out_err;
    pop            = 1'b0;
    mem_we         = 1'b0;
    rd_en          = 1'b0;

    unique case (state)
      rdc_pkg::BK_IDLE: begin
        if (head.valid) begin
          pop          = 1'b1;
          quo_next     = head_value;
          radix_r_next = head_radix;
          rem_next     = '0;
          bit_cnt_next = BIT_W'(VALUE_BITS - 1);
          wr_ptr_next  = '0;
          state_next   = head.base_err ? rdc_pkg::BK_ERR : rdc_pkg::BK_DIV;
        end
      end
      rdc_pkg::BK_DIV: begin
        quo_next = quo_step;
        rem_next = rem_step;
        if (bit_cnt == '0) begin
          mem_we       = 1'b1;
          wr_ptr_next  = wr_ptr + 1'b1;
          rem_next     = '0;
          bit_cnt_next = BIT_W'(VALUE_BITS - 1);
          if (quo_step == '0) begin
            idx_next   = wr_ptr;
            state_next = rdc_pkg::BK_READ;
          end
        end else begin
          bit_cnt_next = bit_cnt - 1'b1;
        end
      end
      rdc_pkg::BK_READ: begin
        rd_en      = 1'b1;
        state_next = rdc_pkg::BK_SEND;
      end
      rdc_pkg::BK_SEND: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = rdc_pkg::digit_to_char(rd_data);
          out_last_next  = (idx == '0);
          out_err_next   = 1'b0;
          if (idx == '0) begin
            state_next = rdc_pkg::BK_IDLE;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = rdc_pkg::BK_READ;
          end
        end
      end
      rdc_pkg::BK_ERR: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_char_next  = rdc_pkg::CHAR_NONE;
          out_last_next  = 1'b1;
          out_err_next   = 1'b1;
          state_next     = rdc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = rdc_pkg::BK_IDLE;
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.digit_char = out_char;
  assign rsp.last_digit = out_last;
  assign rsp.base_error = out_err;

endmodule
`default_nettype wire

// ----- rtl/radix_digit_converter_unit.sv -----
`default_nettype none
// Converts a VALUE_BITS-bit unsigned value to its digits in base 2..36, most
// significant first, one ASCII character ('0'-'9', 'A'-'Z') per rsp transfer,
// with last_digit set on the final one; zero gives a single '0', and a radix
// outside 2..36 gives one transfer with base_error set and digit_char 0. A
// two-entry queue takes requests while the back end works. Each digit comes from
// the one-bit-per-cycle restoring divider and is kept in the digit store; once all
// digits are stored, each is read back from the store and sent, most significant
// first, waiting while rsp is stalled.
module radix_digit_converter_unit #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic clk,
  input  wire logic rst,
  rdc_in_if.sink    req,
  rdc_out_if.source rsp
);

  rdc_pkg::head_ctl_t          head;
  logic [VALUE_BITS-1:0]       head_value;
  logic [rdc_pkg::RADIX_W-1:0] head_radix;
  logic                        pop;

  rdc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .head      (head),
    .head_value(head_value),
    .head_radix(head_radix),
    .pop       (pop)
  );

  rdc_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_value(head_value),
    .head_radix(head_radix),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
`default_nettype wire
